@@ hdl/sbvm_pkg.sv @@
// ----------------------------------------------------------------------------
// sbvm_pkg
// Shared types, constants and helpers of the burst valid-mask parser.
// ----------------------------------------------------------------------------
package sbvm_pkg;

	localparam int WORD_W = 32;  // stream word
	localparam int CFG_W  = 16;  // widest configuration register
	localparam int IDX_W  = 16;  // word / bin / line counters
	localparam int BIN_W  = 17;  // effective bin count, up to 65535
	localparam int HV_W   = 17;  // saturated header value minus one
	localparam int SMP_W  = 16;  // one I or Q sample
	localparam int RBIN_W = 15;  // range_bin output

	localparam logic CFG_BINS  = 1'b0;
	localparam logic CFG_LINES = 1'b1;

	localparam logic [1:0] HDR_RANGE = 2'd0;
	localparam logic [1:0] HDR_FIRST = 2'd1;
	localparam logic [1:0] HDR_LAST  = 2'd2;

	typedef enum logic [2:0] {
		PH_HDR_SKIP,
		PH_HDR_DATA,
		PH_LINE_FIRST,
		PH_LINE_LAST,
		PH_LINE_DATA,
		PH_DONE
	} phase_t;

	// per-word commands from the sequencer to the datapath
	typedef struct packed {
		logic wr_first;  // write first-valid-line table
		logic wr_last;   // write last-valid-line table
		logic rd;        // sample word: read both tables, emit a beat
		logic last_bin;  // final range bin of the line
		logic range_ok;  // bin inside the range window of the line
	} seq_cmd_t;

	// clamp to -65535..65536 as signed, then subtract one
	function automatic logic signed [HV_W-1:0] header_value(input logic [WORD_W-1:0] w);
		logic signed [WORD_W-1:0] s;
		logic signed [WORD_W-1:0] d;
		s = signed'(w);
		d = s - 32'sd1;
		if (s > 32'sd65536)
			return HV_W'(17'sd65535);
		if (s < -32'sd65535)
			return HV_W'(17'h10000);
		return HV_W'(d);
	endfunction

endpackage

@@ hdl/sbvm_ram.sv @@
// ----------------------------------------------------------------------------
// sbvm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sbvm_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 32768,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

@@ hdl/sbvm_seq.sv @@
// ----------------------------------------------------------------------------
// sbvm_seq
// Burst sequencer: tracks header lines, line prefix words and sample words,
// and issues table writes and reads for each accepted word.
// ----------------------------------------------------------------------------
module sbvm_seq #(
	parameter int MAX_BINS = 32768,
	localparam int AW      = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                acc,
	input  logic [sbvm_pkg::WORD_W-1:0]         word,
	input  logic [sbvm_pkg::BIN_W-1:0]          bins_eff,
	input  logic [sbvm_pkg::CFG_W-1:0]          lines,
	output sbvm_pkg::seq_cmd_t                  cmd,
	output logic [AW-1:0]                       tbl_addr,
	output logic signed [sbvm_pkg::HV_W-1:0]    hdr_val,
	output logic [sbvm_pkg::IDX_W-1:0]          bin_idx,
	output logic [sbvm_pkg::IDX_W-1:0]          line_idx
);

	sbvm_pkg::phase_t                       phase_q, phase_d;
	logic [1:0]                             hdr_line_q, hdr_line_d;
	logic [sbvm_pkg::IDX_W-1:0]             word_idx_q, word_idx_d;
	logic [sbvm_pkg::IDX_W-1:0]             line_cnt_q, line_cnt_d;
	logic signed [sbvm_pkg::HV_W-1:0]       rfv_q, rfv_d;
	logic signed [sbvm_pkg::HV_W-1:0]       rlv_q, rlv_d;

	logic [sbvm_pkg::BIN_W-1:0]             idx_inc;
	logic [sbvm_pkg::BIN_W-1:0]             line_inc;
	logic                                   idx_in_range;
	logic                                   idx_last;
	logic [sbvm_pkg::IDX_W-1:0]             tbl_idx;
	logic signed [sbvm_pkg::HV_W:0]         bin_s;
	logic signed [sbvm_pkg::HV_W:0]         rfv_x;
	logic signed [sbvm_pkg::HV_W:0]         rlv_x;

	assign hdr_val      = sbvm_pkg::header_value(word);
	assign idx_inc      = {1'b0, word_idx_q} + sbvm_pkg::BIN_W'(1);
	assign line_inc     = {1'b0, line_cnt_q} + sbvm_pkg::BIN_W'(1);
	assign idx_in_range = ({1'b0, word_idx_q} < bins_eff);
	assign idx_last     = (idx_inc >= bins_eff);
	// clamp the table index to the last bin
	assign tbl_idx      = idx_in_range ? word_idx_q
	                                   : sbvm_pkg::IDX_W'(bins_eff - sbvm_pkg::BIN_W'(1));
	assign tbl_addr     = tbl_idx[AW-1:0];
	assign bin_idx      = word_idx_q;
	assign line_idx     = line_cnt_q;

	assign bin_s = signed'({2'b00, word_idx_q});
	assign rfv_x = {rfv_q[sbvm_pkg::HV_W-1], rfv_q};
	assign rlv_x = {rlv_q[sbvm_pkg::HV_W-1], rlv_q};

	// next state
	always_comb begin
		phase_d    = phase_q;
		hdr_line_d = hdr_line_q;
		word_idx_d = word_idx_q;
		line_cnt_d = line_cnt_q;
		rfv_d      = rfv_q;
		rlv_d      = rlv_q;
		case (phase_q)
			sbvm_pkg::PH_HDR_SKIP: begin
				if (word_idx_q != '0) begin
					word_idx_d = '0;
					phase_d    = sbvm_pkg::PH_HDR_DATA;
				end else begin
					word_idx_d = word_idx_q + sbvm_pkg::IDX_W'(1);
				end
			end
			sbvm_pkg::PH_HDR_DATA: begin
				if (idx_last) begin
					word_idx_d = '0;
					if (hdr_line_q >= sbvm_pkg::HDR_LAST) begin
						hdr_line_d = sbvm_pkg::HDR_RANGE;
						line_cnt_d = '0;
						phase_d    = (lines == '0) ? sbvm_pkg::PH_DONE
						                           : sbvm_pkg::PH_LINE_FIRST;
					end else begin
						hdr_line_d = hdr_line_q + 2'd1;
						phase_d    = sbvm_pkg::PH_HDR_SKIP;
					end
				end else begin
					word_idx_d = idx_inc[sbvm_pkg::IDX_W-1:0];
				end
			end
			sbvm_pkg::PH_LINE_FIRST: begin
				rfv_d   = hdr_val;
				phase_d = sbvm_pkg::PH_LINE_LAST;
			end
			sbvm_pkg::PH_LINE_LAST: begin
				rlv_d      = hdr_val;
				word_idx_d = '0;
				phase_d    = sbvm_pkg::PH_LINE_DATA;
			end
			sbvm_pkg::PH_LINE_DATA: begin
				if (idx_last) begin
					word_idx_d = '0;
					if (line_inc >= {1'b0, lines}) begin
						phase_d = sbvm_pkg::PH_DONE;
					end else begin
						line_cnt_d = line_inc[sbvm_pkg::IDX_W-1:0];
						phase_d    = sbvm_pkg::PH_LINE_FIRST;
					end
				end else begin
					word_idx_d = idx_inc[sbvm_pkg::IDX_W-1:0];
				end
			end
			default: begin
				phase_d = sbvm_pkg::PH_DONE;
			end
		endcase
	end

	// outputs
	always_comb begin
		cmd          = '0;
		cmd.last_bin = idx_last;
		cmd.range_ok = !(bin_s < rfv_x || bin_s >= rlv_x);
		case (phase_q)
			sbvm_pkg::PH_HDR_DATA: begin
				cmd.wr_first = acc && idx_in_range && (hdr_line_q == sbvm_pkg::HDR_FIRST);
				cmd.wr_last  = acc && idx_in_range && (hdr_line_q == sbvm_pkg::HDR_LAST);
			end
			sbvm_pkg::PH_LINE_DATA: begin
				cmd.rd = acc;
			end
			default: begin
				cmd.rd = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= sbvm_pkg::PH_HDR_SKIP;
			hdr_line_q <= sbvm_pkg::HDR_RANGE;
			word_idx_q <= '0;
			line_cnt_q <= '0;
			rfv_q      <= '0;
			rlv_q      <= '0;
		end else if (acc) begin
			phase_q    <= phase_d;
			hdr_line_q <= hdr_line_d;
			word_idx_q <= word_idx_d;
			line_cnt_q <= line_cnt_d;
			rfv_q      <= rfv_d;
			rlv_q      <= rlv_d;
		end
	end

endmodule

@@ hdl/sar_burst_valid_mask_parser.sv @@
// ----------------------------------------------------------------------------
// sar_burst_valid_mask_parser
// Parses a SAR burst word stream and masks I/Q pairs outside the valid window.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one 32-bit big-endian stream word per beat (in_valid,
//   in_stall, in_word). Header words and the two prefix words of each line
//   produce no output; every sample word produces one output beat carrying
//   the I/Q pair (zeroed when masked), its range bin and line index, the
//   valid flag and an end-of-line flag.
//   Configuration: cfg_we/cfg_index/cfg_data write bins_per_line (index 0)
//   and lines_per_burst (index 1); write them only while the block is idle.
//   Throughput: one word per cycle while the output is not stalled.
//   Stage 1 holds a sample word while the registered read of the
//   valid-line tables completes; stage 2 is the output register.
//   The first/last valid line tables are two MAX_BINS-deep RAMs written
//   during the header and read for each sample word.
//   Reset: parsing restarts at the first header line, cfg registers go to 1.
//   Table contents are not cleared; they are written by the header.
//   Stall: out_stall holds the output beat; once stage 1 is also full,
//   in_stall rises in the same cycle. After the last line words are taken
//   and dropped until reset.
// ----------------------------------------------------------------------------
module sar_burst_valid_mask_parser #(
	parameter int MAX_BINS = 32768
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic                                 cfg_index,
	input  logic [sbvm_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [sbvm_pkg::WORD_W-1:0]          in_word,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [sbvm_pkg::SMP_W-1:0]    sample_i,
	output logic signed [sbvm_pkg::SMP_W-1:0]    sample_q,
	output logic [sbvm_pkg::RBIN_W-1:0]          range_bin,
	output logic [sbvm_pkg::IDX_W-1:0]           line_index,
	output logic                                 point_valid,
	output logic                                 last_in_line
);

	localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

	logic [sbvm_pkg::CFG_W-1:0]           bins_q;
	logic [sbvm_pkg::CFG_W-1:0]           lines_q;
	logic [sbvm_pkg::BIN_W-1:0]           bins_eff;

	sbvm_pkg::seq_cmd_t                   cmd;
	logic [AW-1:0]                        tbl_addr;
	logic signed [sbvm_pkg::HV_W-1:0]     hdr_val;
	logic [sbvm_pkg::IDX_W-1:0]           bin_idx;
	logic [sbvm_pkg::IDX_W-1:0]           line_idx;
	logic [sbvm_pkg::HV_W-1:0]            first_rd;
	logic [sbvm_pkg::HV_W-1:0]            last_rd;

	logic                                 in_acc;
	logic                                 adv1;
	logic                                 adv2;

	logic                                 v_s1;
	logic [sbvm_pkg::WORD_W-1:0]          word_s1;
	logic [sbvm_pkg::IDX_W-1:0]           bin_s1;
	logic [sbvm_pkg::IDX_W-1:0]           line_s1;
	logic                                 last_s1;
	logic                                 range_ok_s1;

	logic signed [sbvm_pkg::HV_W:0]       line_x;
	logic signed [sbvm_pkg::HV_W:0]       first_x;
	logic signed [sbvm_pkg::HV_W:0]       last_x;
	logic                                 keep;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bins_q  <= sbvm_pkg::CFG_W'(1);
			lines_q <= sbvm_pkg::CFG_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				sbvm_pkg::CFG_BINS:  bins_q  <= cfg_data;
				sbvm_pkg::CFG_LINES: lines_q <= cfg_data;
				default:             bins_q  <= bins_q;
			endcase
		end
	end

	// zero acts as one, anything above the table depth as the depth
	always_comb begin
		bins_eff = {1'b0, bins_q};
		if (bins_q == '0)
			bins_eff = sbvm_pkg::BIN_W'(1);
		else if ({1'b0, bins_q} > sbvm_pkg::BIN_W'(MAX_BINS))
			bins_eff = sbvm_pkg::BIN_W'(MAX_BINS);
	end

	// handshake: output register, then table-read stage
	assign adv2     = !out_valid || !out_stall;
	assign adv1     = !v_s1 || adv2;
	assign in_stall = !adv1;
	assign in_acc   = in_valid && !in_stall;

	sbvm_seq #(
		.MAX_BINS (MAX_BINS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (in_acc),
		.word     (in_word),
		.bins_eff (bins_eff),
		.lines    (lines_q),
		.cmd      (cmd),
		.tbl_addr (tbl_addr),
		.hdr_val  (hdr_val),
		.bin_idx  (bin_idx),
		.line_idx (line_idx)
	);

	sbvm_ram #(
		.WIDTH (sbvm_pkg::HV_W),
		.DEPTH (MAX_BINS)
	) u_first_tbl (
		.clk   (clk),
		.we    (cmd.wr_first),
		.waddr (tbl_addr),
		.wdata (hdr_val),
		.re    (cmd.rd),
		.raddr (tbl_addr),
		.rdata (first_rd)
	);

	sbvm_ram #(
		.WIDTH (sbvm_pkg::HV_W),
		.DEPTH (MAX_BINS)
	) u_last_tbl (
		.clk   (clk),
		.we    (cmd.wr_last),
		.waddr (tbl_addr),
		.wdata (hdr_val),
		.re    (cmd.rd),
		.raddr (tbl_addr),
		.rdata (last_rd)
	);

	// stage 1: hold the sample word while the table read completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (adv1)
			v_s1 <= cmd.rd;
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			word_s1     <= in_word;
			bin_s1      <= bin_idx;
			line_s1     <= line_idx;
			last_s1     <= cmd.last_bin;
			range_ok_s1 <= cmd.range_ok;
		end
	end

	assign line_x  = signed'({2'b00, line_s1[sbvm_pkg::IDX_W-1:0]});
	assign first_x = signed'({first_rd[sbvm_pkg::HV_W-1], first_rd});
	assign last_x  = signed'({last_rd[sbvm_pkg::HV_W-1], last_rd});
	assign keep    = range_ok_s1 && !(line_x < first_x || line_x > last_x);

	// stage 2: output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (adv2)
			out_valid <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			sample_i     <= keep ? signed'(word_s1[31:16]) : '0;
			sample_q     <= keep ? signed'(word_s1[15:0]) : '0;
			range_bin    <= bin_s1[sbvm_pkg::RBIN_W-1:0];
			line_index   <= line_s1;
			point_valid  <= keep;
			last_in_line <= last_s1;
		end
	end

	// a stalled stage 1 must not issue a new read over its pending data
	a_hold_read: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && out_valid && out_stall) |-> !cmd.rd)
		else $error("table read issued while stage 1 is held");

	// header writes and sample reads belong to disjoint phases
	a_no_rw_mix: assert property (@(posedge clk) disable iff (!arst_n)
		!((cmd.wr_first || cmd.wr_last) && cmd.rd))
		else $error("table write and read in the same cycle");

	// masked beats carry zero samples
	a_mask_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !point_valid) |-> (sample_i == '0 && sample_q == '0))
		else $error("masked beat with nonzero samples");

	// a beat leaves stage 1 only into a free or draining output register
	a_s1_move: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && out_valid && out_stall) |=> (v_s1 && out_valid))
		else $error("stage 1 beat lost under stall");

endmodule

@@ bench/tb_sar_burst_valid_mask_parser.sv @@
// ----------------------------------------------------------------------------
// tb_sar_burst_valid_mask_parser
// Self-checking bench for the burst valid-mask parser. One burst runs from
// reset to end. The header is written at the widest bin count used later,
// so every later bin count stays inside written entries. A stimulus table
// then walks the mask corners, followed by one line across every written
// entry and random lines under changing sender and receiver idling. The
// burst ends with trailing words that must be dropped. Every output beat
// is checked field by field against a local parser model or its table row.
// ----------------------------------------------------------------------------
module tb_sar_burst_valid_mask_parser;

	localparam int TBL_DEPTH   = 32768;
	localparam int HDR_BINS    = 64;
	localparam int PIPE_LAT    = 4;
	localparam int QUIET_LIMIT = 1000;
	localparam int RAND_WORDS  = 1600;

	typedef struct packed {
		logic [sbvm_pkg::SMP_W-1:0]  sample_i;
		logic [sbvm_pkg::SMP_W-1:0]  sample_q;
		logic [sbvm_pkg::RBIN_W-1:0] range_bin;
		logic [sbvm_pkg::IDX_W-1:0]  line_index;
		logic                        point_valid;
		logic                        last_in_line;
	} beat_t;

	typedef enum logic [1:0] {ROW_WORD, ROW_BINS, ROW_LINES} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [31:0] val;
		logic        typed;
		beat_t       want;
	} dir_row_t;

	localparam beat_t NO_BEAT = '0;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              cfg_we = 1'b0;
	logic                              cfg_index = sbvm_pkg::CFG_BINS;
	logic [sbvm_pkg::CFG_W-1:0]        cfg_data = '0;
	logic                              in_valid = 1'b0;
	logic                              in_stall;
	logic [sbvm_pkg::WORD_W-1:0]       in_word = '0;
	logic                              out_valid;
	logic                              out_stall = 1'b0;
	logic signed [sbvm_pkg::SMP_W-1:0] sample_i;
	logic signed [sbvm_pkg::SMP_W-1:0] sample_q;
	logic [sbvm_pkg::RBIN_W-1:0]       range_bin;
	logic [sbvm_pkg::IDX_W-1:0]        line_index;
	logic                              point_valid;
	logic                              last_in_line;

	// parser model state
	logic [15:0]        cfg_bins = 16'd1;
	logic [15:0]        cfg_lines = 16'd1;
	sbvm_pkg::phase_t   ph = sbvm_pkg::PH_HDR_SKIP;
	logic [1:0]         hdr_line = sbvm_pkg::HDR_RANGE;
	logic [15:0]        widx = '0;
	logic [15:0]        line_cnt = '0;
	logic signed [16:0] rng_first = '0;
	logic signed [16:0] rng_last = '0;
	logic signed [16:0] first_tbl [0:TBL_DEPTH-1];
	logic signed [16:0] last_tbl [0:TBL_DEPTH-1];

	beat_t pending_beats [$];
	int    n_errors = 0;
	int    quiet_cycles = 0;
	int    send_idle_pct = 0;
	int    recv_stall_pct = 0;

	// corners of the mask: bin 0 of the tables is inside for every line,
	// bin 1 is past its last line, bin 2 before its first line, bin 3 inside
	dir_row_t dir_rows [0:23] = '{
		'{ROW_LINES, 32'd65535,     1'b0, NO_BEAT},
		'{ROW_BINS,  32'd0,         1'b0, NO_BEAT},
		'{ROW_WORD,  32'h0000_0000, 1'b0, NO_BEAT},
		'{ROW_WORD,  32'h0000_0002, 1'b0, NO_BEAT},
		'{ROW_WORD,  32'h8000_7FFF, 1'b1, '{16'h8000, 16'h7FFF, 15'd0, 16'd0, 1'b1, 1'b1}},
		'{ROW_WORD,  32'h8000_0000, 1'b0, NO_BEAT},
		'{ROW_WORD,  32'h8000_0000, 1'b0, NO_BEAT},
		'{ROW_WORD,  32'hFFFF_FFFF, 1'b1, '{16'h0000, 16'h0000, 15'd0, 16'd1, 1'b0, 1'b1}},
		'{ROW_BINS,  32'd4,         1'b0, NO_BEAT},
		'{ROW_WORD,  32'h7FFF_FFFF, 1'b0, NO_BEAT},
		'{ROW_WORD,  32'h7FFF_FFFF, 1'b0, NO_BEAT},
		'{ROW_WORD,  32'h0102_0304, 1'b1, '{16'h0000, 16'h0000, 15'd0, 16'd2, 1'b0, 1'b0}},
		'{ROW_WORD,  32'hFEDC_BA98, 1'b1, '{16'h0000, 16'h0000, 15'd1, 16'd2, 1'b0, 1'b0}},
		'{ROW_WORD,  32'h5555_AAAA, 1'b1, '{16'h0000, 16'h0000, 15'd2, 16'd2, 1'b0, 1'b0}},
		'{ROW_WORD,  32'hAAAA_5555, 1'b1, '{16'h0000, 16'h0000, 15'd3, 16'd2, 1'b0, 1'b1}},
		'{ROW_WORD,  32'hFFFF_0001, 1'b0, NO_BEAT},
		'{ROW_WORD,  32'h0001_0000, 1'b0, NO_BEAT},
		'{ROW_WORD,  32'h1234_ABCD, 1'b0, NO_BEAT},
		'{ROW_WORD,  32'h0000_FFFF, 1'b0, NO_BEAT},
		// drop the bin count below the current bin: the line ends on the next word
		'{ROW_BINS,  32'd1,         1'b0, NO_BEAT},
		'{ROW_WORD,  32'hFFFF_8000, 1'b0, NO_BEAT},
		'{ROW_WORD,  32'h0000_0001, 1'b0, NO_BEAT},
		'{ROW_WORD,  32'h0000_0001, 1'b0, NO_BEAT},
		'{ROW_WORD,  32'h7FFF_0000, 1'b0, NO_BEAT}
	};

	sar_burst_valid_mask_parser #(
		.MAX_BINS(TBL_DEPTH)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_word     (in_word),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.sample_i    (sample_i),
		.sample_q    (sample_q),
		.range_bin   (range_bin),
		.line_index  (line_index),
		.point_valid (point_valid),
		.last_in_line(last_in_line)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int eff_bins();
		int nb;
		nb = int'(cfg_bins);
		if (nb == 0)
			nb = 1;
		if (nb > TBL_DEPTH)
			nb = TBL_DEPTH;
		return nb;
	endfunction

	// read as signed, clamp to -65535..65536, take one off
	function automatic logic signed [16:0] clamp_hdr(input logic [31:0] w);
		int v;
		v = signed'(w);
		if (v > 65536)
			v = 65536;
		else if (v < -65535)
			v = -65535;
		return 17'(v - 1);
	endfunction

	// advance the parser model by one word; returns 1 when a beat results
	function automatic bit parse_word(input logic [31:0] w, output beat_t b);
		int nb;
		int idx;
		int ti;
		int ln;
		bit fin;
		bit ok;
		b = '0;
		nb = eff_bins();
		idx = int'(widx);
		parse_word = 1'b0;
		case (ph)
			sbvm_pkg::PH_HDR_SKIP: begin
				if (widx >= 16'd1) begin
					widx = '0;
					ph = sbvm_pkg::PH_HDR_DATA;
				end else begin
					widx = widx + 16'd1;
				end
			end
			sbvm_pkg::PH_HDR_DATA: begin
				if (idx < nb) begin
					if (hdr_line == sbvm_pkg::HDR_FIRST)
						first_tbl[idx] = clamp_hdr(w);
					else if (hdr_line == sbvm_pkg::HDR_LAST)
						last_tbl[idx] = clamp_hdr(w);
				end
				if (idx + 1 >= nb) begin
					widx = '0;
					if (hdr_line >= sbvm_pkg::HDR_LAST) begin
						hdr_line = sbvm_pkg::HDR_RANGE;
						line_cnt = '0;
						ph = (cfg_lines == 16'd0) ? sbvm_pkg::PH_DONE
						                          : sbvm_pkg::PH_LINE_FIRST;
					end else begin
						hdr_line = hdr_line + 2'd1;
						ph = sbvm_pkg::PH_HDR_SKIP;
					end
				end else begin
					widx = 16'(idx + 1);
				end
			end
			sbvm_pkg::PH_LINE_FIRST: begin
				rng_first = clamp_hdr(w);
				ph = sbvm_pkg::PH_LINE_LAST;
			end
			sbvm_pkg::PH_LINE_LAST: begin
				rng_last = clamp_hdr(w);
				widx = '0;
				ph = sbvm_pkg::PH_LINE_DATA;
			end
			sbvm_pkg::PH_LINE_DATA: begin
				ti = (idx < nb) ? idx : nb - 1;
				ln = int'(line_cnt);
				fin = (idx + 1 >= nb);
				ok = !(ln < first_tbl[ti] || ln > last_tbl[ti] ||
					idx < rng_first || idx >= rng_last);
				b.sample_i = ok ? w[31:16] : '0;
				b.sample_q = ok ? w[15:0] : '0;
				b.range_bin = 15'(idx);
				b.line_index = line_cnt;
				b.point_valid = ok;
				b.last_in_line = fin;
				if (fin) begin
					widx = '0;
					if (int'(line_cnt) + 1 >= int'(cfg_lines)) begin
						ph = sbvm_pkg::PH_DONE;
					end else begin
						line_cnt = line_cnt + 16'd1;
						ph = sbvm_pkg::PH_LINE_FIRST;
					end
				end else begin
					widx = 16'(idx + 1);
				end
				parse_word = 1'b1;
			end
			default: ;
		endcase
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %h actual %h", $time, name, want, got);
			n_errors++;
		end
	endfunction

	function automatic logic [31:0] extreme_word();
		case ($urandom_range(0, 6))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'hFFFF_0001;
			3: return 32'hFFFF_0000;
			4: return 32'h0001_0000;
			5: return 32'h0001_0001;
			default: return 32'h0000_0000;
		endcase
	endfunction

	// first/last valid bin word of a line, mostly within reach of the bin count
	function automatic logic [31:0] window_word(input int span);
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return $urandom;
		if (r == 1)
			return extreme_word();
		return $urandom_range(0, span);
	endfunction

	function automatic void set_idle(input int m);
		case (m)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
			default: begin send_idle_pct = 31; recv_stall_pct = 31; end
		endcase
	endfunction

	task automatic send_word(input logic [31:0] w, input logic typed = 1'b0,
		input beat_t typed_b = '0);
		beat_t b;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (parse_word(w, b))
			pending_beats.push_back(typed ? typed_b : b);
	endtask

	// hold the sender until every beat is out and the pipe has emptied
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (PIPE_LAT) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] val);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == sbvm_pkg::CFG_BINS)
			cfg_bins = val;
		else
			cfg_lines = val;
	endtask

	task automatic send_line();
		send_word(window_word(eff_bins() / 2 + 1));
		send_word(window_word(eff_bins() + 3));
		while (ph == sbvm_pkg::PH_LINE_DATA)
			send_word($urandom);
	endtask

	always @(posedge clk) begin : rx_check
		beat_t want;
		beat_t got;
		if (out_valid && !out_stall) begin
			got = '{sample_i, sample_q, range_bin, line_index, point_valid, last_in_line};
			if (pending_beats.size() == 0) begin
				$display("%0t: output beat with nothing pending, actual %h", $time, got);
				n_errors++;
			end else begin
				want = pending_beats.pop_front();
				check_field("sample_i", want.sample_i, got.sample_i);
				check_field("sample_q", want.sample_q, got.sample_q);
				check_field("range_bin", want.range_bin, got.range_bin);
				check_field("line_index", want.line_index, got.line_index);
				check_field("point_valid", want.point_valid, got.point_valid);
				check_field("last_in_line", want.last_in_line, got.last_in_line);
			end
		end
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		logic [31:0] hw;
		int rnd_words;
		int cut;
		int sent;
		set_idle(0);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// widest bin count of the run: later lines only read written entries
		write_reg(sbvm_pkg::CFG_BINS, 16'(HDR_BINS));
		write_reg(sbvm_pkg::CFG_LINES, 16'd1);

		set_idle(3);
		for (int hl = 0; hl < 3; hl++) begin
			send_word($urandom);
			send_word($urandom);
			for (int k = 0; k < eff_bins(); k++) begin
				if (hl == 0)
					hw = $urandom;
				else if (k == 0)
					hw = (hl == 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
				else if (k == 1)
					hw = 32'h0000_0000;
				else if (k == 2)
					hw = (hl == 1) ? 32'h0001_0001 : 32'h7FFF_FFFF;
				else if (k == 3)
					hw = (hl == 1) ? 32'hFFFF_0001 : 32'h0001_0000;
				else if ($urandom_range(0, 15) == 0)
					hw = $urandom;
				else if ($urandom_range(0, 15) == 0)
					hw = extreme_word();
				else
					hw = (hl == 1) ? $urandom_range(0, 60) : $urandom_range(0, 160);
				send_word(hw);
			end
		end

		set_idle(1);
		for (int r = 0; r < 24; r++) begin
			case (dir_rows[r].kind)
				ROW_BINS:  write_reg(sbvm_pkg::CFG_BINS, dir_rows[r].val[15:0]);
				ROW_LINES: write_reg(sbvm_pkg::CFG_LINES, dir_rows[r].val[15:0]);
				default:   send_word(dir_rows[r].val, dir_rows[r].typed, dir_rows[r].want);
			endcase
		end

		// one line across every written table entry, full window
		set_idle(2);
		write_reg(sbvm_pkg::CFG_BINS, 16'(HDR_BINS));
		send_word(32'h0000_0000);
		send_word(32'h0001_0000);
		while (ph == sbvm_pkg::PH_LINE_DATA)
			send_word($urandom);

		write_reg(sbvm_pkg::CFG_BINS, 16'd8);
		rnd_words = 0;
		while (rnd_words < RAND_WORDS) begin
			set_idle(rnd_words * 4 / RAND_WORDS);
			if ($urandom_range(0, 5) == 0)
				write_reg(sbvm_pkg::CFG_BINS, 16'(($urandom_range(0, 7) == 0) ?
					$urandom_range(0, 2) : $urandom_range(1, 40)));
			if ($urandom_range(0, 19) == 0)
				wait_idle();
			send_word(window_word(eff_bins() / 2 + 1));
			send_word(window_word(eff_bins() + 3));
			rnd_words += 2;
			cut = ($urandom_range(0, 9) == 0 && eff_bins() > 1) ?
				$urandom_range(1, eff_bins() - 1) : -1;
			sent = 0;
			while (ph == sbvm_pkg::PH_LINE_DATA) begin
				// change the bin count in the middle of a line
				if (sent == cut)
					write_reg(sbvm_pkg::CFG_BINS, 16'($urandom_range(0, 40)));
				send_word($urandom);
				sent++;
				rnd_words++;
			end
		end

		// end the burst after one more line, then feed words that must drop
		set_idle(3);
		write_reg(sbvm_pkg::CFG_LINES, 16'd0);
		send_line();
		repeat (30) send_word($urandom);

		in_valid <= 1'b0;
		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (n_errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/sbvm_pkg.sv
hdl/sbvm_ram.sv
hdl/sbvm_seq.sv
hdl/sar_burst_valid_mask_parser.sv
bench/tb_sar_burst_valid_mask_parser.sv
